// ----- sv/plcp_pkg.sv -----
// Shared types and constants for the lens-corrected point pipeline.
// No dependencies; every other file but plcp_dly refers to it by scoped names.
package plcp_pkg;

	// Internal datapath word: signed, 64 bits, as the fixed-point formats need.
	localparam int DW = 64;
	typedef logic signed [DW-1:0] word_t;

	// Saturation limits of the datapath word.
	localparam logic [DW-1:0] MAX64 = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MIN64 = {1'b1, {(DW-1){1'b0}}};

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RADIAL_K1   = 3'd0,
		CFG_RADIAL_K2   = 3'd1,
		CFG_RADIAL_K3   = 3'd2,
		CFG_DECENTER_P1 = 3'd3,
		CFG_DECENTER_P2 = 3'd4,
		CFG_PRINCIPAL_X = 3'd5,
		CFG_PRINCIPAL_Y = 3'd6,
		CFG_PIXEL_PITCH = 3'd7
	} cfg_idx_t;

	// Register file contents as seen by the datapath.
	typedef struct packed {
		logic signed [31:0] radial_k1;
		logic signed [31:0] radial_k2;
		logic signed [31:0] radial_k3;
		logic signed [31:0] decenter_p1;
		logic signed [31:0] decenter_p2;
		logic signed [31:0] principal_x;
		logic signed [31:0] principal_y;
		logic        [31:0] pixel_pitch;
	} cfg_t;

endpackage

// ----- sv/plcp_dly.sv -----
// Fixed-length delay line with a shared stall enable, used to align operands.
// Depends on nothing; payload only, so it has no reset.
module plcp_dly #(
	parameter int W     = 64,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_s [DEPTH];

	// Shift one place per advancing cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[DEPTH-1];

endmodule

// ----- sv/plcp_mulsh.sv -----
// Four-stage saturating signed multiply with a constant right shift of the magnitude.
// Depends on plcp_pkg for the word type and the saturation limit.
module plcp_mulsh #(
	parameter int SH = 24
) (
	input  logic           clk,
	input  logic           en,
	input  plcp_pkg::word_t a,
	input  plcp_pkg::word_t b,
	output plcp_pkg::word_t p,
	output logic           sat
);

	logic        neg_s1, neg_s2, neg_s3;
	logic [63:0] ma_s1, mb_s1;
	logic [63:0] q0_s2, q1_s2, q2_s2, q3_s2;
	logic [127:0] prod_s3;
	logic [127:0] shifted;
	logic        ovf;
	logic [63:0] mag;
	plcp_pkg::word_t p_s4;
	logic        sat_s4;

	// Magnitude of the truncated product, clipped to the largest positive word.
	assign shifted = prod_s3 >> SH;
	assign ovf     = |shifted[127:63];
	assign mag     = ovf ? plcp_pkg::MAX64 : {1'b0, shifted[62:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: sign of the result and operand magnitudes.
			neg_s1 <= a[63] ^ b[63];
			ma_s1  <= a[63] ? (64'd0 - 64'(a)) : 64'(a);
			mb_s1  <= b[63] ? (64'd0 - 64'(b)) : 64'(b);
			// Stage 2: four 32 by 32 partial products.
			neg_s2 <= neg_s1;
			q0_s2  <= ma_s1[31:0]  * mb_s1[31:0];
			q1_s2  <= ma_s1[31:0]  * mb_s1[63:32];
			q2_s2  <= ma_s1[63:32] * mb_s1[31:0];
			q3_s2  <= ma_s1[63:32] * mb_s1[63:32];
			// Stage 3: full 128-bit product.
			neg_s3  <= neg_s2;
			prod_s3 <= {64'd0, q0_s2} + {32'd0, q1_s2, 32'd0} + {32'd0, q2_s2, 32'd0}
				+ {q3_s2, 64'd0};
			// Stage 4: shift, saturate and restore the sign.
			p_s4   <= neg_s3 ? plcp_pkg::word_t'(64'd0 - mag) : plcp_pkg::word_t'(mag);
			sat_s4 <= ovf;
		end
	end

	assign p   = p_s4;
	assign sat = sat_s4;

endmodule

// ----- sv/plcp_cfg.sv -----
// Configuration register file for the distortion coefficients and camera geometry.
// Depends on plcp_pkg for the register indexes and the register struct.
module plcp_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [plcp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                        cfg_data,
	output plcp_pkg::cfg_t                     regs
);

	plcp_pkg::cfg_t regs_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;

	// Decode the index and update one register per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_valid) begin
			unique case (plcp_pkg::cfg_idx_t'(cfg_index))
				plcp_pkg::CFG_RADIAL_K1:   regs_q.radial_k1   <= cfg_data;
				plcp_pkg::CFG_RADIAL_K2:   regs_q.radial_k2   <= cfg_data;
				plcp_pkg::CFG_RADIAL_K3:   regs_q.radial_k3   <= cfg_data;
				plcp_pkg::CFG_DECENTER_P1: regs_q.decenter_p1 <= cfg_data;
				plcp_pkg::CFG_DECENTER_P2: regs_q.decenter_p2 <= cfg_data;
				plcp_pkg::CFG_PRINCIPAL_X: regs_q.principal_x <= cfg_data;
				plcp_pkg::CFG_PRINCIPAL_Y: regs_q.principal_y <= cfg_data;
				plcp_pkg::CFG_PIXEL_PITCH: regs_q.pixel_pitch <= cfg_data;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ----- sv/pixel_to_lens_corrected_point.sv -----
// Top level: pixel position to Brown-Conrady corrected image-plane point.
// Depends on plcp_pkg, plcp_cfg, plcp_mulsh and plcp_dly.
//
// Usage:
//   Pixel positions arrive on the s_axis stream (row and column in Q12.4, a
//   missing flag in tuser) and corrected points leave on the m_axis stream
//   (x and y in signed Q8.24 millimetres, missing and saturated flags in tuser).
//   Coefficients and geometry are written through the cfg channel; the user must
//   write them only while the stream is idle, as the block does not enforce it.
//   The cfg channel is always ready. Throughput is one item per cycle while the
//   receiver keeps up; the depth is set by the chain of four-stage multipliers
//   pitch, u*u, r4, r6, k3*r6 and u*F with the sums between them.
//   Every stage moves together on one enable. When the receiver stalls with a
//   result waiting, the pipeline keeps advancing as long as its last stage is
//   empty and then holds; nothing is dropped or repeated.
//   Reset clears all valid bits and sets every configuration register to zero.
//   A missing input gives x = y = 0, missing = 1 and saturated = 0.
module pixel_to_lens_corrected_point #(
	parameter int HALF_COLS = 1024,
	parameter int HALF_ROWS = 768
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // row_pos [15:0], col_pos [31:16]
	input  logic [0:0]  s_axis_tuser,   // in_missing [0]
	// Output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // corr_x [31:0], corr_y [63:32]
	output logic [1:0]  m_axis_tuser,   // out_missing [0], saturated [1]
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [plcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	typedef struct packed {
		plcp_pkg::word_t val;
		logic            sat;
	} sadd_t;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} clip_t;

	localparam int NSTG = 31;
	localparam logic [17:0] COL_OFS = 18'(HALF_COLS * 16);
	localparam logic [17:0] ROW_OFS = 18'(HALF_ROWS * 16);

	// Saturating 64-bit add.
	function automatic sadd_t sat_add(input plcp_pkg::word_t a, input plcp_pkg::word_t b);
		logic [64:0] s;
		sadd_t       r;
		s     = {a[63], a} + {b[63], b};
		r.sat = s[64] ^ s[63];
		if (r.sat) begin
			r.val = s[64] ? plcp_pkg::MIN64 : plcp_pkg::MAX64;
		end else begin
			r.val = s[63:0];
		end
		return r;
	endfunction

	// Clip to the signed 32-bit range.
	function automatic clip_t clip32(input plcp_pkg::word_t a);
		clip_t r;
		if (!a[63] && (|a[62:31])) begin
			r.val = 32'h7FFF_FFFF;
			r.sat = 1'b1;
		end else if (a[63] && !(&a[62:31])) begin
			r.val = 32'h8000_0000;
			r.sat = 1'b1;
		end else begin
			r.val = a[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	plcp_pkg::cfg_t cfg;
	logic           en;

	logic [NSTG:1] vld_s, miss_s, sat_s, sat_in;

	logic signed [17:0] dc_s1, dr_s1;
	plcp_pkg::word_t px_s5, py_s5, px_s30, py_s30;
	plcp_pkg::word_t u_s6, v_s6, u_s24, v_s24;
	plcp_pkg::word_t uu_s10, vv_s10, uv_s10;
	plcp_pkg::word_t r2_s11, uu2_s11, vv2_s11, uv2_s11, r2_s15;
	plcp_pkg::word_t pdx_s12, pdy_s12;
	plcp_pkg::word_t r4_s15, k1r2_s15, k1r2_s19, r6_s19, k2r4_s19;
	plcp_pkg::word_t fa_s20, fa_s23, k3r6_s23, f_s24;
	plcp_pkg::word_t uf_s28, vf_s28;
	plcp_pkg::word_t p1uv2_s15, p2uv2_s15, p1pdx_s16, p2pdy_s16;
	plcp_pkg::word_t p1pdx_s28, p1uv2_s28, p2uv2_s29, p2pdy_s29;
	plcp_pkg::word_t ex1_s29, ey1_s29, ex_s30, ey_s30, sx_s31, sy_s31;

	logic sat_px, sat_py, sat_uu, sat_vv, sat_uv, sat_r4, sat_k1r2, sat_r6, sat_k2r4;
	logic sat_k3r6, sat_uf, sat_vf, sat_p1uv2, sat_p2uv2, sat_p1pdx, sat_p2pdy;

	sadd_t r2_c, uu2_c, vv2_c, uv2_c, pdx_c, pdy_c, fa_c, f_c;
	sadd_t ex1_c, ey1_c, ex_c, ey_c, sx_c, sy_c;
	clip_t cx_c, cy_c;

	logic        out_vld_q, out_miss_q, out_sat_q;
	logic [31:0] out_x_q, out_y_q;

	plcp_cfg i_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (cfg)
	);

	// Global stage enable: move unless a result waits and the last stage is full.
	assign en            = !out_vld_q || m_axis_tready || !vld_s[NSTG];
	assign s_axis_tready = en;

	// Stage 1: offsets from the image centre in Q.4.
	always_ff @(posedge clk) begin
		if (en) begin
			dc_s1 <= $signed({2'b00, s_axis_tdata[31:16]}) - $signed(COL_OFS);
			dr_s1 <= $signed(ROW_OFS) - $signed({2'b00, s_axis_tdata[15:0]});
		end
	end

	// Stages 2 to 5: scale by the pixel pitch into Q.24 millimetres.
	plcp_mulsh #(.SH(12)) i_px (.clk(clk), .en(en), .a(plcp_pkg::word_t'(dc_s1)),
		.b(plcp_pkg::word_t'({32'd0, cfg.pixel_pitch})), .p(px_s5), .sat(sat_px));
	plcp_mulsh #(.SH(12)) i_py (.clk(clk), .en(en), .a(plcp_pkg::word_t'(dr_s1)),
		.b(plcp_pkg::word_t'({32'd0, cfg.pixel_pitch})), .p(py_s5), .sat(sat_py));

	// Stage 6: offsets from the principal point.
	always_ff @(posedge clk) begin
		if (en) begin
			u_s6 <= px_s5 - plcp_pkg::word_t'(cfg.principal_x);
			v_s6 <= py_s5 - plcp_pkg::word_t'(cfg.principal_y);
		end
	end

	// Stages 7 to 10: squares and cross product.
	plcp_mulsh #(.SH(24)) i_uu (.clk(clk), .en(en), .a(u_s6), .b(u_s6), .p(uu_s10),
		.sat(sat_uu));
	plcp_mulsh #(.SH(24)) i_vv (.clk(clk), .en(en), .a(v_s6), .b(v_s6), .p(vv_s10),
		.sat(sat_vv));
	plcp_mulsh #(.SH(24)) i_uv (.clk(clk), .en(en), .a(u_s6), .b(v_s6), .p(uv_s10),
		.sat(sat_uv));

	// Stage 11 and 12 sums: r2, doubled terms, decentering brackets.
	assign r2_c  = sat_add(uu_s10, vv_s10);
	assign uu2_c = sat_add(uu_s10, uu_s10);
	assign vv2_c = sat_add(vv_s10, vv_s10);
	assign uv2_c = sat_add(uv_s10, uv_s10);
	assign pdx_c = sat_add(r2_s11, uu2_s11);
	assign pdy_c = sat_add(r2_s11, vv2_s11);

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s11  <= r2_c.val;
			uu2_s11 <= uu2_c.val;
			vv2_s11 <= vv2_c.val;
			uv2_s11 <= uv2_c.val;
			pdx_s12 <= pdx_c.val;
			pdy_s12 <= pdy_c.val;
		end
	end

	// Radial powers and the first two radial terms.
	plcp_mulsh #(.SH(24)) i_r4 (.clk(clk), .en(en), .a(r2_s11), .b(r2_s11), .p(r4_s15),
		.sat(sat_r4));
	plcp_mulsh #(.SH(24)) i_k1r2 (.clk(clk), .en(en),
		.a(plcp_pkg::word_t'(cfg.radial_k1)), .b(r2_s11), .p(k1r2_s15), .sat(sat_k1r2));
	plcp_dly #(.W(plcp_pkg::DW), .DEPTH(4)) i_d_r2 (.clk(clk), .en(en), .d(r2_s11),
		.q(r2_s15));

	plcp_mulsh #(.SH(24)) i_r6 (.clk(clk), .en(en), .a(r4_s15), .b(r2_s15), .p(r6_s19),
		.sat(sat_r6));
	plcp_mulsh #(.SH(32)) i_k2r4 (.clk(clk), .en(en),
		.a(plcp_pkg::word_t'(cfg.radial_k2)), .b(r4_s15), .p(k2r4_s19), .sat(sat_k2r4));
	plcp_dly #(.W(plcp_pkg::DW), .DEPTH(4)) i_d_k1r2 (.clk(clk), .en(en), .d(k1r2_s15),
		.q(k1r2_s19));

	// Stage 20: first two radial terms.
	assign fa_c = sat_add(k1r2_s19, k2r4_s19);

	plcp_mulsh #(.SH(40)) i_k3r6 (.clk(clk), .en(en),
		.a(plcp_pkg::word_t'(cfg.radial_k3)), .b(r6_s19), .p(k3r6_s23), .sat(sat_k3r6));
	plcp_dly #(.W(plcp_pkg::DW), .DEPTH(3)) i_d_fa (.clk(clk), .en(en), .d(fa_s20),
		.q(fa_s23));

	// Stage 24: radial factor F with 40 fraction bits.
	assign f_c = sat_add(fa_s23, k3r6_s23);

	always_ff @(posedge clk) begin
		if (en) begin
			fa_s20 <= fa_c.val;
			f_s24  <= f_c.val;
		end
	end

	plcp_dly #(.W(plcp_pkg::DW), .DEPTH(18)) i_d_u (.clk(clk), .en(en), .d(u_s6),
		.q(u_s24));
	plcp_dly #(.W(plcp_pkg::DW), .DEPTH(18)) i_d_v (.clk(clk), .en(en), .d(v_s6),
		.q(v_s24));

	plcp_mulsh #(.SH(40)) i_uf (.clk(clk), .en(en), .a(u_s24), .b(f_s24), .p(uf_s28),
		.sat(sat_uf));
	plcp_mulsh #(.SH(40)) i_vf (.clk(clk), .en(en), .a(v_s24), .b(f_s24), .p(vf_s28),
		.sat(sat_vf));

	// Decentering products, computed early and held until the radial path catches up.
	plcp_mulsh #(.SH(40)) i_p1uv2 (.clk(clk), .en(en),
		.a(plcp_pkg::word_t'(cfg.decenter_p1)), .b(uv2_s11), .p(p1uv2_s15), .sat(sat_p1uv2));
	plcp_mulsh #(.SH(40)) i_p2uv2 (.clk(clk), .en(en),
		.a(plcp_pkg::word_t'(cfg.decenter_p2)), .b(uv2_s11), .p(p2uv2_s15), .sat(sat_p2uv2));
	plcp_mulsh #(.SH(40)) i_p1pdx (.clk(clk), .en(en),
		.a(plcp_pkg::word_t'(cfg.decenter_p1)), .b(pdx_s12), .p(p1pdx_s16), .sat(sat_p1pdx));
	plcp_mulsh #(.SH(40)) i_p2pdy (.clk(clk), .en(en),
		.a(plcp_pkg::word_t'(cfg.decenter_p2)), .b(pdy_s12), .p(p2pdy_s16), .sat(sat_p2pdy));

	plcp_dly #(.W(plcp_pkg::DW), .DEPTH(12)) i_d_p1pdx (.clk(clk), .en(en), .d(p1pdx_s16),
		.q(p1pdx_s28));
	plcp_dly #(.W(plcp_pkg::DW), .DEPTH(13)) i_d_p1uv2 (.clk(clk), .en(en), .d(p1uv2_s15),
		.q(p1uv2_s28));
	plcp_dly #(.W(plcp_pkg::DW), .DEPTH(14)) i_d_p2uv2 (.clk(clk), .en(en), .d(p2uv2_s15),
		.q(p2uv2_s29));
	plcp_dly #(.W(plcp_pkg::DW), .DEPTH(13)) i_d_p2pdy (.clk(clk), .en(en), .d(p2pdy_s16),
		.q(p2pdy_s29));
	plcp_dly #(.W(plcp_pkg::DW), .DEPTH(25)) i_d_px (.clk(clk), .en(en), .d(px_s5),
		.q(px_s30));
	plcp_dly #(.W(plcp_pkg::DW), .DEPTH(25)) i_d_py (.clk(clk), .en(en), .d(py_s5),
		.q(py_s30));

	// Stages 29 to 31: accumulate the corrections in the model's order.
	assign ex1_c = sat_add(uf_s28, p1pdx_s28);
	assign ey1_c = sat_add(vf_s28, p1uv2_s28);
	assign ex_c  = sat_add(ex1_s29, p2uv2_s29);
	assign ey_c  = sat_add(ey1_s29, p2pdy_s29);
	assign sx_c  = sat_add(px_s30, ex_s30);
	assign sy_c  = sat_add(py_s30, ey_s30);

	always_ff @(posedge clk) begin
		if (en) begin
			ex1_s29 <= ex1_c.val;
			ey1_s29 <= ey1_c.val;
			ex_s30  <= ex_c.val;
			ey_s30  <= ey_c.val;
			sx_s31  <= sx_c.val;
			sy_s31  <= sy_c.val;
		end
	end

	// Saturation events, each OR-ed in at the stage its item occupies.
	always_comb begin
		sat_in     = '0;
		sat_in[6]  = sat_px | sat_py;
		sat_in[11] = sat_uu | sat_vv | sat_uv | r2_c.sat | uu2_c.sat | vv2_c.sat | uv2_c.sat;
		sat_in[12] = pdx_c.sat | pdy_c.sat;
		sat_in[16] = sat_r4 | sat_k1r2 | sat_p1uv2 | sat_p2uv2;
		sat_in[17] = sat_p1pdx | sat_p2pdy;
		sat_in[20] = sat_r6 | sat_k2r4 | fa_c.sat;
		sat_in[24] = sat_k3r6 | f_c.sat;
		sat_in[29] = sat_uf | sat_vf | ex1_c.sat | ey1_c.sat;
		sat_in[30] = ex_c.sat | ey_c.sat;
		sat_in[31] = sx_c.sat | sy_c.sat;
	end

	// Per-stage missing and saturation flags travel with the data.
	always_ff @(posedge clk) begin
		if (en) begin
			miss_s <= {miss_s[NSTG-1:1], s_axis_tuser[0]};
			sat_s  <= {sat_s[NSTG-1:1], 1'b0} | sat_in;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-1:1], s_axis_tvalid};
		end
	end

	// Output register: final clip, missing points forced to zero.
	assign cx_c = clip32(sx_s31);
	assign cy_c = clip32(sy_s31);

	always_ff @(posedge clk) begin
		if (en && vld_s[NSTG]) begin
			if (miss_s[NSTG]) begin
				out_x_q    <= '0;
				out_y_q    <= '0;
				out_miss_q <= 1'b1;
				out_sat_q  <= 1'b0;
			end else begin
				out_x_q    <= cx_c.val;
				out_y_q    <= cy_c.val;
				out_miss_q <= 1'b0;
				out_sat_q  <= sat_s[NSTG] | cx_c.sat | cy_c.sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en && vld_s[NSTG]) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_y_q, out_x_q};
	assign m_axis_tuser  = {out_sat_q, out_miss_q};

	// An accepted item enters stage 1 with its missing flag.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_s[1] && (miss_s[1] == $past(s_axis_tuser[0])))
		else $error("accepted item did not enter the first stage");

	// No input is taken while a full last stage is blocked by a waiting result.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NSTG] && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("pipeline advanced over a blocked result");

	// The last stage keeps its item while the output is stalled.
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NSTG] && m_axis_tvalid && !m_axis_tready |=> vld_s[NSTG])
		else $error("last stage item lost during stall");

	// A delivered result with nothing behind it leaves the output empty.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !vld_s[NSTG] |=> !m_axis_tvalid)
		else $error("result repeated after transfer");

endmodule

// ----- tb/sv/pixel_to_lens_corrected_point_tb.sv -----
// Self-checking testbench for pixel_to_lens_corrected_point: pixel positions in,
// Brown-Conrady corrected image-plane points out, checked against an in-bench predictor.
// Depends on plcp_pkg and the pixel_to_lens_corrected_point RTL.
module pixel_to_lens_corrected_point_tb;

	localparam int HALF_COLS = 1024;
	localparam int HALF_ROWS = 768;
	// Settle time after the last result, longer than the pipeline is deep.
	localparam int SETTLE_CYCLES = 64;
	// Length of the long receiver hold-off that backs the pipeline up to its input.
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [15:0] row;
		logic [15:0] col;
		logic        missing;
	} pixel_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic        missing;
		logic        clipped;
	} corr_point_t;

	typedef enum {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_RARE_STALL} ready_style_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // row_pos [15:0], col_pos [31:16]
	logic [0:0]  s_axis_tuser;   // in_missing [0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;   // corr_x [31:0], corr_y [63:32]
	logic [1:0]  m_axis_tuser;   // out_missing [0], saturated [1]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [plcp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	// Local copy of the lens registers, updated on each configuration transfer.
	plcp_pkg::cfg_t lens_cfg;
	// Corrected points predicted for accepted pixels, oldest first.
	corr_point_t pending_points[$];
	int          mismatches;
	int          burst_left;
	bit          gaps_on;
	bit          hold_request;

	pixel_to_lens_corrected_point #(
		.HALF_COLS(HALF_COLS),
		.HALF_ROWS(HALF_ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Fixed-point helpers of the predictor. The overflow flag is sticky.

	function automatic longint sext32(input logic [31:0] w);
		return longint'({{32{w[31]}}, w});
	endfunction

	// Exact product, magnitude shifted right (rounds toward zero), saturated to 64 bits.
	function automatic longint mul_shift(input longint a, input longint b, input int sh,
			inout bit ovf);
		logic [63:0]  ma;
		logic [63:0]  mb;
		logic [63:0]  mag;
		logic [127:0] prod;
		bit           neg;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? 64'(-a) : 64'(a);
		mb = (b < 0) ? 64'(-b) : 64'(b);
		prod = ({64'd0, ma} * {64'd0, mb}) >> sh;
		if (prod[127:63] != '0) begin
			ovf = 1'b1;
			mag = plcp_pkg::MAX64;
		end else begin
			mag = prod[63:0];
		end
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic longint add_sat(input longint a, input longint b, inout bit ovf);
		longint s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			ovf = 1'b1;
			return a[63] ? $signed(plcp_pkg::MIN64) : $signed(plcp_pkg::MAX64);
		end
		return s;
	endfunction

	function automatic logic [31:0] clip_to_32(input longint a, inout bit ovf);
		if (a > 64'sd2147483647) begin
			ovf = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (a < -64'sd2147483648) begin
			ovf = 1'b1;
			return 32'h8000_0000;
		end
		return a[31:0];
	endfunction

	// Predicts the corrected point for one pixel under the current lens registers.
	function automatic corr_point_t corrected_point(input pixel_t p);
		corr_point_t res;
		bit          ovf;
		longint      pitch, dc, dr, px, py, u, v, uu, vv, uv, uv2, r2, r4, r6;
		longint      f, ex, ey, t;
		res = '0;
		ovf = 1'b0;
		if (p.missing) begin
			res.missing = 1'b1;
			return res;
		end
		// Offsets from the image centre in Q.4, times the pitch, give Q.24 millimetres.
		pitch = longint'({32'd0, lens_cfg.pixel_pitch});
		dc = longint'({48'd0, p.col}) - HALF_COLS * 16;
		dr = HALF_ROWS * 16 - longint'({48'd0, p.row});
		px = mul_shift(dc, pitch, 12, ovf);
		py = mul_shift(dr, pitch, 12, ovf);
		u = px - sext32(lens_cfg.principal_x);
		v = py - sext32(lens_cfg.principal_y);
		uu = mul_shift(u, u, 24, ovf);
		vv = mul_shift(v, v, 24, ovf);
		uv = mul_shift(u, v, 24, ovf);
		r2 = add_sat(uu, vv, ovf);
		r4 = mul_shift(r2, r2, 24, ovf);
		r6 = mul_shift(r4, r2, 24, ovf);
		// Radial factor carries 40 fraction bits.
		f = mul_shift(sext32(lens_cfg.radial_k1), r2, 24, ovf);
		t = mul_shift(sext32(lens_cfg.radial_k2), r4, 32, ovf);
		f = add_sat(f, t, ovf);
		t = mul_shift(sext32(lens_cfg.radial_k3), r6, 40, ovf);
		f = add_sat(f, t, ovf);
		uv2 = add_sat(uv, uv, ovf);
		// Correction along x: radial part plus both decentering terms.
		ex = mul_shift(u, f, 40, ovf);
		t = add_sat(uu, uu, ovf);
		t = add_sat(r2, t, ovf);
		t = mul_shift(sext32(lens_cfg.decenter_p1), t, 40, ovf);
		ex = add_sat(ex, t, ovf);
		t = mul_shift(sext32(lens_cfg.decenter_p2), uv2, 40, ovf);
		ex = add_sat(ex, t, ovf);
		// Correction along y.
		ey = mul_shift(v, f, 40, ovf);
		t = mul_shift(sext32(lens_cfg.decenter_p1), uv2, 40, ovf);
		ey = add_sat(ey, t, ovf);
		t = add_sat(vv, vv, ovf);
		t = add_sat(r2, t, ovf);
		t = mul_shift(sext32(lens_cfg.decenter_p2), t, 40, ovf);
		ey = add_sat(ey, t, ovf);
		t = add_sat(px, ex, ovf);
		res.x = clip_to_32(t, ovf);
		t = add_sat(py, ey, ovf);
		res.y = clip_to_32(t, ovf);
		res.clipped = ovf;
		return res;
	endfunction

	// Checks every output transfer against the oldest predicted point.
	always @(posedge clk) begin
		corr_point_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual x=%h y=%h user=%b",
					$time, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
			end else begin
				want = pending_points.pop_front();
				if (m_axis_tdata[31:0] !== want.x) begin
					mismatches++;
					$display("%0t: corr_x expected %h actual %h", $time, want.x,
						m_axis_tdata[31:0]);
				end
				if (m_axis_tdata[63:32] !== want.y) begin
					mismatches++;
					$display("%0t: corr_y expected %h actual %h", $time, want.y,
						m_axis_tdata[63:32]);
				end
				if (m_axis_tuser[0] !== want.missing) begin
					mismatches++;
					$display("%0t: out_missing expected %b actual %b", $time, want.missing,
						m_axis_tuser[0]);
				end
				if (m_axis_tuser[1] !== want.clipped) begin
					mismatches++;
					$display("%0t: saturated expected %b actual %b", $time, want.clipped,
						m_axis_tuser[1]);
				end
			end
		end
	end

	// Receiver: stretches of one ready style each, and a long hold-off on request.
	initial begin
		ready_style_t style;
		int           stretch_left;
		int           period;
		int           tick;
		style = RX_ALWAYS;
		stretch_left = 0;
		period = 2;
		tick = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				if (stretch_left == 0) begin
					style = ready_style_t'($urandom_range(0, 3));
					stretch_left = $urandom_range(10, 150);
					period = $urandom_range(2, 5);
				end
				stretch_left--;
				tick++;
				case (style)
					RX_ALWAYS: m_axis_tready <= 1'b1;
					RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
					RX_PERIODIC: m_axis_tready <= (tick % period) == 0;
					default: m_axis_tready <= $urandom_range(0, 15) != 0;
				endcase
			end
		end
	end

	// Writes one lens register. Entered at a falling edge; it leaves at a falling edge
	// after the release of cfg_valid.
	task automatic write_reg(input plcp_pkg::cfg_idx_t idx, input logic [31:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			plcp_pkg::CFG_RADIAL_K1: lens_cfg.radial_k1 = value;
			plcp_pkg::CFG_RADIAL_K2: lens_cfg.radial_k2 = value;
			plcp_pkg::CFG_RADIAL_K3: lens_cfg.radial_k3 = value;
			plcp_pkg::CFG_DECENTER_P1: lens_cfg.decenter_p1 = value;
			plcp_pkg::CFG_DECENTER_P2: lens_cfg.decenter_p2 = value;
			plcp_pkg::CFG_PRINCIPAL_X: lens_cfg.principal_x = value;
			plcp_pkg::CFG_PRINCIPAL_Y: lens_cfg.principal_y = value;
			default: lens_cfg.pixel_pitch = value;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_lens(input plcp_pkg::cfg_t c);
		write_reg(plcp_pkg::CFG_RADIAL_K1, c.radial_k1);
		write_reg(plcp_pkg::CFG_RADIAL_K2, c.radial_k2);
		write_reg(plcp_pkg::CFG_RADIAL_K3, c.radial_k3);
		write_reg(plcp_pkg::CFG_DECENTER_P1, c.decenter_p1);
		write_reg(plcp_pkg::CFG_DECENTER_P2, c.decenter_p2);
		write_reg(plcp_pkg::CFG_PRINCIPAL_X, c.principal_x);
		write_reg(plcp_pkg::CFG_PRINCIPAL_Y, c.principal_y);
		write_reg(plcp_pkg::CFG_PIXEL_PITCH, c.pixel_pitch);
	endtask

	// Offers one pixel and records its prediction on the transfer. Keeps tvalid high
	// into the next pixel unless the current burst has run out.
	task automatic send_pixel(input pixel_t p);
		s_axis_tdata <= {p.col, p.row};
		s_axis_tuser <= p.missing;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pending_points.push_back(corrected_point(p));
		@(negedge clk);
		if (gaps_on) begin
			burst_left--;
			if (burst_left <= 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	task automatic send_at(input logic [15:0] row, input logic [15:0] col,
			input logic missing);
		pixel_t p;
		p.row = row;
		p.col = col;
		p.missing = missing;
		send_pixel(p);
	endtask

	// Stops offering and waits until every predicted point has been checked.
	task automatic drain_points();
		s_axis_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(negedge clk);
	endtask

	function automatic pixel_t random_pixel();
		pixel_t p;
		if ($urandom_range(0, 3) == 0) begin
			p.row = 16'($urandom);
			p.col = 16'($urandom);
		end else begin
			p.row = 16'($urandom_range(0, HALF_ROWS * 32 - 1));
			p.col = 16'($urandom_range(0, HALF_COLS * 32 - 1));
		end
		p.missing = $urandom_range(0, 7) == 0;
		return p;
	endfunction

	// Signed word with a random magnitude range, from tiny to full scale.
	function automatic logic [31:0] spread_word();
		return $signed($urandom) >>> $urandom_range(0, 31);
	endfunction

	function automatic logic [31:0] corner_word();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return 32'h0000_0001;
		endcase
	endfunction

	// With every register at zero the pitch is zero, so every point lands at the origin.
	task automatic test_reset_state();
		send_at(16'h0000, 16'h0000, 1'b0);
		send_at(16'hFFFF, 16'hFFFF, 1'b0);
		send_at(16'd12288, 16'd16384, 1'b0);
		send_at(16'h1234, 16'h8765, 1'b1);
		drain_points();
	endtask

	// A plausible lens, the corners of the coordinate range, the image centre and missing points.
	task automatic test_nominal_lens();
		plcp_pkg::cfg_t c;
		c.radial_k1 = -32'sd200_000_000;
		c.radial_k2 = 32'sd50_000_000;
		c.radial_k3 = -32'sd1_000_000;
		c.decenter_p1 = 32'sd3_000_000;
		c.decenter_p2 = -32'sd2_000_000;
		c.principal_x = 32'sh0008_0000;
		c.principal_y = -32'sh0004_0000;
		c.pixel_pitch = 32'd14_817_637;
		load_lens(c);
		send_at(16'h0000, 16'h0000, 1'b0);
		send_at(16'hFFFF, 16'hFFFF, 1'b0);
		send_at(16'h0000, 16'hFFFF, 1'b0);
		send_at(16'hFFFF, 16'h0000, 1'b0);
		send_at(16'd12288, 16'd16384, 1'b0);
		send_at(16'hAAAA, 16'h5555, 1'b0);
		send_at(16'h5555, 16'hAAAA, 1'b0);
		send_at(16'hFFFF, 16'hFFFF, 1'b1);
		send_at(16'h0000, 16'h0000, 1'b1);
		drain_points();
	endtask

	// Saturation: extreme registers clip the output; a large but legal pitch with no
	// distortion overflows r2^3 internally while the coordinates stay in range.
	task automatic test_saturation();
		plcp_pkg::cfg_t c;
		c.radial_k1 = 32'h7FFF_FFFF;
		c.radial_k2 = 32'h8000_0000;
		c.radial_k3 = 32'h7FFF_FFFF;
		c.decenter_p1 = 32'h8000_0000;
		c.decenter_p2 = 32'h7FFF_FFFF;
		c.principal_x = 32'h7FFF_FFFF;
		c.principal_y = 32'h8000_0000;
		c.pixel_pitch = 32'hFFFF_FFFF;
		load_lens(c);
		send_at(16'h0000, 16'h0000, 1'b0);
		send_at(16'hFFFF, 16'hFFFF, 1'b0);
		send_at(16'd12288, 16'd16384, 1'b0);
		send_at(16'hFFFF, 16'h0000, 1'b1);
		drain_points();
		c = '0;
		c.pixel_pitch = 32'd400_000_000;
		load_lens(c);
		send_at(16'h0000, 16'h0000, 1'b0);
		send_at(16'd12288, 16'd16384, 1'b0);
		drain_points();
	endtask

	// Random pixels under a series of lens settings: plausible, spread and extreme.
	task automatic test_random_lenses();
		plcp_pkg::cfg_t c;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase % 3)
				0: begin
					c.radial_k1 = spread_word();
					c.radial_k2 = spread_word();
					c.radial_k3 = spread_word();
					c.decenter_p1 = spread_word();
					c.decenter_p2 = spread_word();
					c.principal_x = $urandom_range(0, 1 << 24) - (1 << 23);
					c.principal_y = $urandom_range(0, 1 << 24) - (1 << 23);
					c.pixel_pitch = $urandom_range(4_000_000, 40_000_000);
				end
				1: begin
					c.radial_k1 = spread_word();
					c.radial_k2 = spread_word();
					c.radial_k3 = spread_word();
					c.decenter_p1 = spread_word();
					c.decenter_p2 = spread_word();
					c.principal_x = spread_word();
					c.principal_y = spread_word();
					c.pixel_pitch = $urandom >> $urandom_range(0, 31);
				end
				default: begin
					c.radial_k1 = corner_word();
					c.radial_k2 = corner_word();
					c.radial_k3 = corner_word();
					c.decenter_p1 = corner_word();
					c.decenter_p2 = corner_word();
					c.principal_x = corner_word();
					c.principal_y = corner_word();
					c.pixel_pitch = corner_word();
				end
			endcase
			load_lens(c);
			// Odd phases stream back to back, even phases in bursts.
			gaps_on = (phase % 2) == 0;
			burst_left = $urandom_range(1, 24);
			repeat (260) send_pixel(random_pixel());
			drain_points();
		end
	endtask

	// The receiver holds off for a long stretch while pixels keep coming, so the
	// pipeline fills and stalls its input.
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_request = 1'b1;
		repeat (150) send_pixel(random_pixel());
		drain_points();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = plcp_pkg::CFG_RADIAL_K1;
		cfg_data = '0;
		lens_cfg = '0;
		mismatches = 0;
		burst_left = 1;
		gaps_on = 1'b1;
		hold_request = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_state();
		test_nominal_lens();
		test_saturation();
		test_random_lenses();
		test_backpressure();
		// Catch any result that arrives after the last one expected.
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Overall time limit, far above the slowest correct run.
	initial begin
		#3_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
